@@ hw/rtl/owtr_pkg.sv @@
`timescale 1ns / 1ps

package owtr_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int DUR_W          = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERSION      = 3'd7;

    localparam logic signed [15:0] ABSENT_TEMP = -16'sd1600;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    localparam logic [2:0] BYTE_CONVERT = 3'd2;
    localparam logic [2:0] BYTE_READ_LO = 3'd4;
    localparam logic [2:0] BYTE_READ_HI = 3'd5;
    localparam logic [2:0] BIT_LAST     = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_W_RECOV  = 4'd6,
        PH_CONVERT  = 4'd7,
        PH_R_START  = 4'd8,
        PH_R_WAIT   = 4'd9,
        PH_R_TAIL   = 4'd10
    } phase_t;

    typedef struct packed {
        logic action;
        logic bus_level;
    } in_item_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              no_sensor;
        logic signed [15:0] temperature;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  reset_low_us;
        logic [7:0]  presence_sample_us;
        logic [9:0]  reset_tail_us;
        logic [3:0]  slot_start_us;
        logic [6:0]  write_slot_us;
        logic [5:0]  read_sample_us;
        logic [6:0]  read_tail_us;
        logic [19:0] conversion_us;
    } cfg_t;

    function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SP;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/one_wire_temperature_reader.sv @@
// Latency: a result beat is valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the sequencer and its tick timer
// finish each beat in one pass; a waiting result holds off input until taken.
// Reset (rst_n low, asynchronous): config returns to its defaults, the
// sequencer goes idle with the line released, and no result beat is pending.
`timescale 1ns / 1ps

module one_wire_temperature_reader #(
    parameter int TIMER_BITS = owtr_pkg::TIMER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  owtr_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output owtr_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import owtr_pkg::*;

    cfg_t      cfg_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t result;
    logic      accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    owtr_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .item    (in_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us       <= 10'd600;
            cfg_reg.presence_sample_us <= 8'd60;
            cfg_reg.reset_tail_us      <= 10'd400;
            cfg_reg.slot_start_us      <= 4'd2;
            cfg_reg.write_slot_us      <= 7'd60;
            cfg_reg.read_sample_us     <= 6'd12;
            cfg_reg.read_tail_us       <= 7'd50;
            cfg_reg.conversion_us      <= 20'd750000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW:       cfg_reg.reset_low_us       <= cfg_data[9:0];
                CFG_PRESENCE_SAMPLE: cfg_reg.presence_sample_us <= cfg_data[7:0];
                CFG_RESET_TAIL:      cfg_reg.reset_tail_us      <= cfg_data[9:0];
                CFG_SLOT_START:      cfg_reg.slot_start_us      <= cfg_data[3:0];
                CFG_WRITE_SLOT:      cfg_reg.write_slot_us      <= cfg_data[6:0];
                CFG_READ_SAMPLE:     cfg_reg.read_sample_us     <= cfg_data[5:0];
                CFG_READ_TAIL:       cfg_reg.read_tail_us       <= cfg_data[6:0];
                default:             cfg_reg.conversion_us      <= cfg_data[19:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/owtr_core.sv @@
`timescale 1ns / 1ps

module owtr_core #(
    parameter int TIMER_BITS = owtr_pkg::TIMER_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  owtr_pkg::in_item_t  item,
    input  owtr_pkg::cfg_t      cfg,
    output owtr_pkg::out_item_t result
);
    import owtr_pkg::*;

    localparam int WIDE = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

    phase_t                  phase_reg, phase_next;
    logic [2:0]              byte_step_reg, byte_step_next;
    logic [2:0]              bit_step_reg, bit_step_next;
    logic [TIMER_BITS-1:0]   timer_reg, timer_next;
    logic [7:0]              shift_reg, shift_next;
    logic [7:0]              low_byte_reg, low_byte_next;
    logic signed [15:0]      temp_reg, temp_next;
    logic                    absent_reg, absent_next;
    logic                    drive_reg, drive_next;

    logic                    done;
    logic                    load;
    logic [DUR_W-1:0]        dur_sel;
    logic [TIMER_BITS-1:0]   timer_dec;
    logic [WIDE-1:0]         dur_wide;
    logic [WIDE-1:0]         lim_wide;
    logic [TIMER_BITS-1:0]   timer_load;
    logic [7:0]              shifted;
    logic [2:0]              byte_inc;

    assign timer_dec = (timer_reg != '0) ? timer_reg - TIMER_BITS'(1) : '0;
    assign dur_wide  = WIDE'(dur_sel);
    assign lim_wide  = WIDE'({TIMER_BITS{1'b1}});
    assign timer_load = (dur_wide > lim_wide) ? TIMER_BITS'(lim_wide)
                                              : TIMER_BITS'(dur_wide);
    assign shifted   = {1'b0, shift_reg[7:1]};
    assign byte_inc  = byte_step_reg + 3'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        byte_step_next = byte_step_reg;
        bit_step_next  = bit_step_reg;
        shift_next     = shift_reg;
        low_byte_next  = low_byte_reg;
        temp_next      = temp_reg;
        absent_next    = absent_reg;
        drive_next     = drive_reg;
        done           = 1'b0;
        load           = 1'b0;
        dur_sel        = '0;
        timer_next     = timer_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (item.action)
            begin
                byte_step_next = '0;
                bit_step_next  = '0;
                phase_next     = PH_RST_LOW;
                dur_sel        = DUR_W'(cfg.reset_low_us);
                load           = 1'b1;
                drive_next     = 1'b1;
            end
        end
        else if (!item.action)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                unique case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                        dur_sel    = DUR_W'(cfg.presence_sample_us);
                        load       = 1'b1;
                        drive_next = 1'b0;
                    end
                    PH_RST_WAIT:
                    begin
                        shift_next = {7'd0, item.bus_level};
                        phase_next = PH_RST_TAIL;
                        dur_sel    = DUR_W'(cfg.reset_tail_us);
                        load       = 1'b1;
                        drive_next = 1'b0;
                    end
                    PH_RST_TAIL:
                    begin
                        if (byte_step_reg == 3'd0 && shift_reg[0])
                        begin
                            absent_next = 1'b1;
                            temp_next   = ABSENT_TEMP;
                            phase_next  = PH_IDLE;
                            timer_next  = '0;
                            drive_next  = 1'b0;
                            done        = 1'b1;
                        end
                        else
                        begin
                            shift_next    = cmd_byte(byte_step_reg[1:0]);
                            bit_step_next = '0;
                            phase_next    = PH_W_START;
                            dur_sel       = DUR_W'(cfg.slot_start_us);
                            load          = 1'b1;
                            drive_next    = 1'b1;
                        end
                    end
                    PH_W_START:
                    begin
                        phase_next = PH_W_HOLD;
                        dur_sel    = DUR_W'(cfg.write_slot_us);
                        load       = 1'b1;
                        drive_next = ~shift_reg[0];
                    end
                    PH_W_HOLD:
                    begin
                        phase_next = PH_W_RECOV;
                        dur_sel    = DUR_W'(cfg.slot_start_us);
                        load       = 1'b1;
                        drive_next = 1'b0;
                    end
                    PH_W_RECOV:
                    begin
                        shift_next = shifted;
                        load       = 1'b1;
                        if (bit_step_reg < BIT_LAST)
                        begin
                            bit_step_next = bit_step_reg + 3'd1;
                            phase_next    = PH_W_START;
                            dur_sel       = DUR_W'(cfg.slot_start_us);
                            drive_next    = 1'b1;
                        end
                        else
                        begin
                            bit_step_next = '0;
                            byte_step_next = byte_inc;
                            if (byte_inc == BYTE_CONVERT)
                            begin
                                phase_next = PH_CONVERT;
                                dur_sel    = cfg.conversion_us;
                                drive_next = 1'b0;
                            end
                            else if (byte_inc >= BYTE_READ_LO)
                            begin
                                byte_step_next = BYTE_READ_LO;
                                phase_next     = PH_R_START;
                                dur_sel        = DUR_W'(cfg.slot_start_us);
                                drive_next     = 1'b1;
                            end
                            else
                            begin
                                shift_next = cmd_byte(byte_inc[1:0]);
                                phase_next = PH_W_START;
                                dur_sel    = DUR_W'(cfg.slot_start_us);
                                drive_next = 1'b1;
                            end
                        end
                    end
                    PH_CONVERT:
                    begin
                        phase_next = PH_RST_LOW;
                        dur_sel    = DUR_W'(cfg.reset_low_us);
                        load       = 1'b1;
                        drive_next = 1'b1;
                    end
                    PH_R_START:
                    begin
                        phase_next = PH_R_WAIT;
                        dur_sel    = DUR_W'(cfg.read_sample_us);
                        load       = 1'b1;
                        drive_next = 1'b0;
                    end
                    PH_R_WAIT:
                    begin
                        shift_next = {item.bus_level, shift_reg[7:1]};
                        phase_next = PH_R_TAIL;
                        dur_sel    = DUR_W'(cfg.read_tail_us);
                        load       = 1'b1;
                        drive_next = 1'b0;
                    end
                    PH_R_TAIL:
                    begin
                        if (bit_step_reg < BIT_LAST)
                        begin
                            bit_step_next = bit_step_reg + 3'd1;
                            phase_next    = PH_R_START;
                            dur_sel       = DUR_W'(cfg.slot_start_us);
                            load          = 1'b1;
                            drive_next    = 1'b1;
                        end
                        else if (byte_step_reg == BYTE_READ_LO)
                        begin
                            bit_step_next  = '0;
                            low_byte_next  = shift_reg;
                            byte_step_next = BYTE_READ_HI;
                            phase_next     = PH_R_START;
                            dur_sel        = DUR_W'(cfg.slot_start_us);
                            load           = 1'b1;
                            drive_next     = 1'b1;
                        end
                        else
                        begin
                            bit_step_next = '0;
                            temp_next     = {shift_reg, low_byte_reg};
                            absent_next   = 1'b0;
                            phase_next    = PH_IDLE;
                            timer_next    = '0;
                            drive_next    = 1'b0;
                            done          = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        timer_next = '0;
                        drive_next = 1'b0;
                        done       = 1'b1;
                    end
                endcase
            end
        end

        if (load)
        begin
            timer_next = timer_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            byte_step_reg <= '0;
            bit_step_reg  <= '0;
            timer_reg     <= '0;
            shift_reg     <= '0;
            low_byte_reg  <= '0;
            temp_reg      <= '0;
            absent_reg    <= 1'b0;
            drive_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            byte_step_reg <= byte_step_next;
            bit_step_reg  <= bit_step_next;
            timer_reg     <= timer_next;
            shift_reg     <= shift_next;
            low_byte_reg  <= low_byte_next;
            temp_reg      <= temp_next;
            absent_reg    <= absent_next;
            drive_reg     <= drive_next;
        end
    end

    assign result.drive_low   = drive_next;
    assign result.busy_res    = (phase_next != PH_IDLE);
    assign result.done_res    = done;
    assign result.no_sensor   = absent_next;
    assign result.temperature = temp_next;

endmodule

@@ hw/rtl/owtr_checker.sv @@
`timescale 1ns / 1ps

module owtr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  owtr_pkg::out_item_t                 out_data
);
    import owtr_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // accept whenever no result waits
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done beat reports busy");

    a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res |-> !out_data.drive_low)
        else $error("line driven while idle");

    a_absent_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res && out_data.no_sensor
            |-> out_data.temperature == ABSENT_TEMP)
        else $error("missing sensor without fallback temperature");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (.*);

@@ tb/one_wire_temperature_reader_tb.sv @@
`timescale 1ns / 1ps

module one_wire_temperature_reader_tb;
    import owtr_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    one_wire_temperature_reader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sequencer mirror
    cfg_t        active_cfg;
    phase_t      seq_phase;
    logic [2:0]  byte_idx;
    logic [2:0]  bit_idx;
    logic [19:0] tick_count;
    logic [7:0]  shift_reg;
    logic [7:0]  low_byte;
    logic [15:0] temp_reg;
    logic        absent_reg;
    logic        drive_reg;

    // sensor behavior for the current measurement
    logic        sensor_present;
    logic [15:0] sensor_temp;

    out_item_t expected_results[$];
    out_item_t oldest_result;

    bit idle_en;
    bit stall_request;
    int mismatch_count;
    int results_checked;
    int work_beats;
    int measurements;
    int absent_runs;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [7:0] command_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd1:    b = CMD_CONVERT;
            2'd3:    b = CMD_READ_SP;
            default: b = CMD_SKIP_ROM;
        endcase
        return b;
    endfunction

    function automatic void enter_phase(input phase_t p, input logic [19:0] dur,
                                        input logic drv);
        seq_phase  = p;
        tick_count = dur;
        drive_reg  = drv;
    endfunction

    function automatic void go_idle();
        seq_phase  = PH_IDLE;
        tick_count = '0;
        drive_reg  = 1'b0;
    endfunction

    function automatic logic finish_step(input logic level);
        logic fin;
        fin = 1'b0;
        case (seq_phase)
            PH_RST_LOW:
                enter_phase(PH_RST_WAIT, 20'(active_cfg.presence_sample_us), 1'b0);
            PH_RST_WAIT:
            begin
                shift_reg = {7'd0, level};
                enter_phase(PH_RST_TAIL, 20'(active_cfg.reset_tail_us), 1'b0);
            end
            PH_RST_TAIL:
            begin
                if (byte_idx == 3'd0 && shift_reg[0])
                begin
                    absent_reg = 1'b1;
                    temp_reg   = ABSENT_TEMP;
                    go_idle();
                    fin = 1'b1;
                end
                else
                begin
                    shift_reg = command_byte(byte_idx[1:0]);
                    bit_idx   = 3'd0;
                    enter_phase(PH_W_START, 20'(active_cfg.slot_start_us), 1'b1);
                end
            end
            PH_W_START:
                enter_phase(PH_W_HOLD, 20'(active_cfg.write_slot_us), !shift_reg[0]);
            PH_W_HOLD:
                enter_phase(PH_W_RECOV, 20'(active_cfg.slot_start_us), 1'b0);
            PH_W_RECOV:
            begin
                shift_reg = shift_reg >> 1;
                if (bit_idx != BIT_LAST)
                begin
                    bit_idx = bit_idx + 3'd1;
                    enter_phase(PH_W_START, 20'(active_cfg.slot_start_us), 1'b1);
                end
                else
                begin
                    bit_idx  = 3'd0;
                    byte_idx = byte_idx + 3'd1;
                    if (byte_idx == BYTE_CONVERT)
                        enter_phase(PH_CONVERT, active_cfg.conversion_us, 1'b0);
                    else if (byte_idx >= BYTE_READ_LO)
                    begin
                        byte_idx = BYTE_READ_LO;
                        enter_phase(PH_R_START, 20'(active_cfg.slot_start_us), 1'b1);
                    end
                    else
                    begin
                        shift_reg = command_byte(byte_idx[1:0]);
                        enter_phase(PH_W_START, 20'(active_cfg.slot_start_us), 1'b1);
                    end
                end
            end
            PH_CONVERT:
                enter_phase(PH_RST_LOW, 20'(active_cfg.reset_low_us), 1'b1);
            PH_R_START:
                enter_phase(PH_R_WAIT, 20'(active_cfg.read_sample_us), 1'b0);
            PH_R_WAIT:
            begin
                shift_reg = {level, shift_reg[7:1]};
                enter_phase(PH_R_TAIL, 20'(active_cfg.read_tail_us), 1'b0);
            end
            PH_R_TAIL:
            begin
                if (bit_idx != BIT_LAST)
                begin
                    bit_idx = bit_idx + 3'd1;
                    enter_phase(PH_R_START, 20'(active_cfg.slot_start_us), 1'b1);
                end
                else
                begin
                    bit_idx = 3'd0;
                    if (byte_idx == BYTE_READ_LO)
                    begin
                        low_byte = shift_reg;
                        byte_idx = BYTE_READ_HI;
                        enter_phase(PH_R_START, 20'(active_cfg.slot_start_us), 1'b1);
                    end
                    else
                    begin
                        temp_reg   = {shift_reg, low_byte};
                        absent_reg = 1'b0;
                        go_idle();
                        fin = 1'b1;
                    end
                end
            end
            default:
            begin
                go_idle();
                fin = 1'b1;
            end
        endcase
        return fin;
    endfunction

    function automatic out_item_t predict_beat(input in_item_t it);
        out_item_t r;
        logic      fin;
        fin = 1'b0;
        if (seq_phase == PH_IDLE)
        begin
            if (it.action)
            begin
                byte_idx = 3'd0;
                bit_idx  = 3'd0;
                enter_phase(PH_RST_LOW, 20'(active_cfg.reset_low_us), 1'b1);
            end
        end
        else if (!it.action)
        begin
            if (tick_count != 0)
                tick_count = tick_count - 20'd1;
            if (tick_count == 0)
                fin = finish_step(it.bus_level);
        end
        r.drive_low   = drive_reg;
        r.busy_res    = (seq_phase != PH_IDLE);
        r.done_res    = fin;
        r.no_sensor   = absent_reg;
        r.temperature = temp_reg;
        return r;
    endfunction

    // answer the master like a sensor on the sampling ticks
    function automatic in_item_t sensor_beat();
        in_item_t it;
        logic     ends;
        it.action    = 1'b0;
        it.bus_level = 1'($urandom_range(0, 1));
        ends = (tick_count <= 20'd1);
        if (ends && seq_phase == PH_RST_WAIT && byte_idx == 3'd0)
            it.bus_level = !sensor_present;
        else if (ends && seq_phase == PH_R_WAIT)
            it.bus_level = sensor_temp[{byte_idx == BYTE_READ_HI, bit_idx}];
        return it;
    endfunction

    task automatic send_beat(input in_item_t it);
        int gap;
        if (idle_en && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (seq_phase == PH_IDLE ? it.action : !it.action)
            work_beats++;
        expected_results.push_back(predict_beat(it));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val,
                             input int w);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        mask = (20'd1 << w) - 20'd1;
        junk = CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (junk & ~mask) | (val & mask);
    endtask

    task automatic apply_config(input cfg_t c);
        drain();
        write_reg(CFG_RESET_LOW,       20'(c.reset_low_us),       10);
        write_reg(CFG_PRESENCE_SAMPLE, 20'(c.presence_sample_us), 8);
        write_reg(CFG_RESET_TAIL,      20'(c.reset_tail_us),      10);
        write_reg(CFG_SLOT_START,      20'(c.slot_start_us),      4);
        write_reg(CFG_WRITE_SLOT,      20'(c.write_slot_us),      7);
        write_reg(CFG_READ_SAMPLE,     20'(c.read_sample_us),     6);
        write_reg(CFG_READ_TAIL,       20'(c.read_tail_us),       7);
        write_reg(CFG_CONVERSION,      c.conversion_us,           20);
        @(negedge clk);
        cfg_we <= 1'b0;
        active_cfg = c;
    endtask

    task automatic run_measurement(input logic present, input logic [15:0] temp,
                                   input int noise);
        in_item_t it;
        int       k;
        sensor_present = present;
        sensor_temp    = temp;
        k = $urandom_range(0, 2);
        repeat (k)
        begin
            it.action    = 1'b0;
            it.bus_level = 1'($urandom_range(0, 1));
            send_beat(it);
        end
        it.action    = 1'b1;
        it.bus_level = 1'($urandom_range(0, 1));
        send_beat(it);
        while (seq_phase != PH_IDLE)
        begin
            it = sensor_beat();
            if ($urandom_range(0, 99) < noise)
            begin
                if ($urandom_range(0, 1) != 0)
                    it.action = 1'b1;
                else
                    it.bus_level = ~it.bus_level;
            end
            send_beat(it);
        end
        measurements++;
        if (absent_reg)
            absent_runs++;
    endtask

    function automatic cfg_t fastest_cfg();
        cfg_t c;
        c = '0;
        c.slot_start_us = 4'd1;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.reset_low_us       = 10'($urandom_range(0, 6));
        c.presence_sample_us = 8'($urandom_range(0, 6));
        c.reset_tail_us      = 10'($urandom_range(0, 6));
        c.slot_start_us      = 4'($urandom_range(1, 3));
        c.write_slot_us      = 7'($urandom_range(0, 6));
        c.read_sample_us     = 6'($urandom_range(0, 6));
        c.read_tail_us       = 7'($urandom_range(0, 6));
        c.conversion_us      = 20'($urandom_range(0, 40));
        case ($urandom_range(0, 11))
            0:       c.reset_low_us       = 10'($urandom_range(0, 255));
            1:       c.presence_sample_us = 8'($urandom_range(0, 255));
            2:       c.reset_tail_us      = 10'($urandom_range(0, 255));
            3:       c.slot_start_us      = 4'($urandom_range(1, 15));
            4:       c.write_slot_us      = 7'($urandom_range(0, 31));
            5:       c.read_sample_us     = 6'($urandom_range(0, 31));
            6:       c.read_tail_us       = 7'($urandom_range(0, 31));
            7:       c.conversion_us      = 20'($urandom_range(0, 400));
            default: ;
        endcase
        return c;
    endfunction

    task automatic test_reset_defaults_no_sensor();
        idle_en = 1'b1;
        run_measurement(1'b0, 16'($urandom_range(0, 65535)), 0);
    endtask

    task automatic test_fastest_timing();
        apply_config(fastest_cfg());
        idle_en = 1'b0;
        run_measurement(1'b1, 16'h7FFF, 0);
        run_measurement(1'b1, 16'h8000, 0);
        idle_en = 1'b1;
        run_measurement(1'b1, 16'h0000, 0);
        run_measurement(1'b1, 16'hFFFF, 4);
        run_measurement(1'b0, 16'h1234, 4);
    endtask

    task automatic test_output_stall();
        apply_config(fastest_cfg());
        idle_en       = 1'b1;
        stall_request = 1'b1;
        run_measurement(1'b1, 16'($urandom_range(0, 65535)), 3);
    endtask

    task automatic test_random_traffic();
        int start_beats;
        int runs;
        start_beats = work_beats;
        while (work_beats - start_beats < RANDOM_BEATS)
        begin
            apply_config(random_cfg());
            idle_en = ($urandom_range(0, 3) != 0);
            runs = $urandom_range(1, 2);
            repeat (runs)
                run_measurement($urandom_range(0, 5) != 0,
                                16'($urandom_range(0, 65535)), 5);
        end
    endtask

    task automatic test_back_to_back();
        apply_config(fastest_cfg());
        idle_en = 1'b0;
        run_measurement(1'b1, 16'h0550, 0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, out_data);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                check_field("drive_low", 16'(oldest_result.drive_low),
                            16'(out_data.drive_low));
                check_field("busy_res", 16'(oldest_result.busy_res),
                            16'(out_data.busy_res));
                check_field("done_res", 16'(oldest_result.done_res),
                            16'(out_data.done_res));
                check_field("no_sensor", 16'(oldest_result.no_sensor),
                            16'(out_data.no_sensor));
                check_field("temperature", oldest_result.temperature,
                            out_data.temperature);
                results_checked++;
            end
        end
    end

    initial
    begin : sink
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                stall_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_en       = 1'b0;
        stall_request = 1'b0;
        mismatch_count  = 0;
        results_checked = 0;
        work_beats      = 0;
        measurements    = 0;
        absent_runs     = 0;
        active_cfg.reset_low_us       = 10'd600;
        active_cfg.presence_sample_us = 8'd60;
        active_cfg.reset_tail_us      = 10'd400;
        active_cfg.slot_start_us      = 4'd2;
        active_cfg.write_slot_us      = 7'd60;
        active_cfg.read_sample_us     = 6'd12;
        active_cfg.read_tail_us       = 7'd50;
        active_cfg.conversion_us      = 20'd750000;
        seq_phase  = PH_IDLE;
        byte_idx   = '0;
        bit_idx    = '0;
        tick_count = '0;
        shift_reg  = '0;
        low_byte   = '0;
        temp_reg   = '0;
        absent_reg = 1'b0;
        drive_reg  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults_no_sensor();
        test_fastest_timing();
        test_output_stall();
        test_random_traffic();
        test_back_to_back();

        drain();
        repeat (4) @(posedge clk);
        $display("Ran %0d measurements (%0d without a sensor) over %0d working beats,",
                 measurements, absent_runs, work_beats);
        $display("%0d result beats checked across default, fast and random timings.",
                 results_checked);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
